### design/gbtf_pkg.sv
// ----------------------------------------------------------------------------
// gbtf_pkg: shared types and constants for the tilt filter
// Widths, fixed-point constants, atan table, controller states and commands.
// ----------------------------------------------------------------------------
package gbtf_pkg;

   localparam int CAL_SAMPLES_DEF  = 2000;
   localparam int CORDIC_STEPS_DEF = 16;

   // bias division: numerator |sum| * 256 + half divisor, multiplied by the
   // reciprocal of CAL_SAMPLES in two half-width passes
   localparam int DIV_W     = 36;
   localparam int DIV_STEPS = 2;
   // step counter: CORDIC iterations (up to 24) and division passes
   localparam int CNT_W = 5;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_ALPHA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_GAIN   = 2'd1;

   localparam logic [16:0] ALPHA_RESET = 17'd65405;
   localparam logic [16:0] ALPHA_ONE   = 17'd65536;
   localparam logic [23:0] GAIN_RESET  = 24'd196716;
   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;
   localparam logic signed [27:0] HALF_TURN = 28'sd11796480;
   localparam logic signed [31:0] ANG_LIMIT = 32'sd67108864;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CAL,
      S_DIV_LOAD,
      S_DIV_RUN,
      S_DIV_STORE,
      S_COR_INIT,
      S_COR_RUN,
      S_MAG,
      S_TRK_MUL,
      S_TRK_G,
      S_TRK_MIX,
      S_TRK_SUM,
      S_OUT
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       cal_add;
      logic       div_load;
      logic       div_step;
      logic       div_store;
      logic       cor_init;
      logic       cor_step;
      logic [4:0] cor_idx;
      logic       mag;
      logic       trk_mul;
      logic       trk_g;
      logic       trk_mix;
      logic       trk_sum;
      logic       axis;      // 0: roll / x, 1: pitch / y
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic cal_done;
      logic cal_last;
   } stat_type;

   // atan(2^-i) in Q16 degrees
   function automatic logic [21:0] atan_deg(input logic [4:0] i);
      logic [21:0] r;
      unique case (i)
         5'd0:    r = 22'd2949120;
         5'd1:    r = 22'd1740967;
         5'd2:    r = 22'd919879;
         5'd3:    r = 22'd466945;
         5'd4:    r = 22'd234379;
         5'd5:    r = 22'd117304;
         5'd6:    r = 22'd58666;
         5'd7:    r = 22'd29335;
         5'd8:    r = 22'd14668;
         5'd9:    r = 22'd7334;
         5'd10:   r = 22'd3667;
         5'd11:   r = 22'd1833;
         5'd12:   r = 22'd917;
         5'd13:   r = 22'd458;
         5'd14:   r = 22'd229;
         5'd15:   r = 22'd115;
         5'd16:   r = 22'd57;
         5'd17:   r = 22'd29;
         5'd18:   r = 22'd14;
         5'd19:   r = 22'd7;
         5'd20:   r = 22'd4;
         5'd21:   r = 22'd2;
         5'd22:   r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

   // saturate to +-1024 degrees in Q16
   function automatic logic signed [27:0] sat_ang(input logic signed [31:0] v);
      logic signed [27:0] r;
      if (v > ANG_LIMIT) begin
         r = ANG_LIMIT[27:0];
      end else if (v < -ANG_LIMIT) begin
         r = 28'(-ANG_LIMIT);
      end else begin
         r = v[27:0];
      end
      return r;
   endfunction

endpackage

### design/gbtf_if.sv
// ----------------------------------------------------------------------------
// gbtf_if: stream channels of the tilt filter
// Sample input, angle result and register write channels.
// ----------------------------------------------------------------------------
interface gbtf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, output ready);
endinterface

interface gbtf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] roll_angle;
   logic signed [16:0] pitch_angle;
   modport source (output valid, roll_angle, pitch_angle, input ready);
   modport sink   (input valid, roll_angle, pitch_angle, output ready);
endinterface

interface gbtf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [gbtf_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [gbtf_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, reg_index, data, input ready);
   modport sink   (input valid, reg_index, data, output ready);
endinterface

### design/gbtf_ctrl.sv
// ----------------------------------------------------------------------------
// gbtf_ctrl: sequencer of the tilt filter
// Steps calibration, bias division, two CORDIC passes and the blend.
// ----------------------------------------------------------------------------
module gbtf_ctrl #(
   parameter int CORDIC_STEPS = gbtf_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  gbtf_pkg::stat_type stat,
   output gbtf_pkg::cmd_type  cmd
);

   localparam int CW = gbtf_pkg::CNT_W;

   gbtf_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                phase_ff, phase_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         gbtf_pkg::S_IDLE: begin
            phase_in = 1'b0;
            if (req_valid) begin
               state_in = stat.cal_done ? gbtf_pkg::S_COR_INIT : gbtf_pkg::S_CAL;
            end
         end
         gbtf_pkg::S_CAL: begin
            state_in = stat.cal_last ? gbtf_pkg::S_DIV_LOAD : gbtf_pkg::S_IDLE;
         end
         gbtf_pkg::S_DIV_LOAD: begin
            cnt_in   = '0;
            state_in = gbtf_pkg::S_DIV_RUN;
         end
         gbtf_pkg::S_DIV_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(gbtf_pkg::DIV_STEPS - 1)) begin
               state_in = gbtf_pkg::S_DIV_STORE;
            end
         end
         gbtf_pkg::S_DIV_STORE: begin
            phase_in = !phase_ff;
            state_in = phase_ff ? gbtf_pkg::S_IDLE : gbtf_pkg::S_DIV_LOAD;
         end
         gbtf_pkg::S_COR_INIT: begin
            cnt_in   = '0;
            state_in = gbtf_pkg::S_COR_RUN;
         end
         gbtf_pkg::S_COR_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
               if (phase_ff) begin
                  phase_in = 1'b0;
                  state_in = gbtf_pkg::S_TRK_MUL;
               end else begin
                  state_in = gbtf_pkg::S_MAG;
               end
            end
         end
         gbtf_pkg::S_MAG: begin
            phase_in = 1'b1;
            state_in = gbtf_pkg::S_COR_INIT;
         end
         gbtf_pkg::S_TRK_MUL: state_in = gbtf_pkg::S_TRK_G;
         gbtf_pkg::S_TRK_G:   state_in = gbtf_pkg::S_TRK_MIX;
         gbtf_pkg::S_TRK_MIX: state_in = gbtf_pkg::S_TRK_SUM;
         gbtf_pkg::S_TRK_SUM: begin
            phase_in = !phase_ff;
            state_in = phase_ff ? gbtf_pkg::S_OUT : gbtf_pkg::S_TRK_MUL;
         end
         gbtf_pkg::S_OUT: begin
            if (out_free) begin
               state_in = gbtf_pkg::S_IDLE;
            end
         end
         default: state_in = gbtf_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.axis     = phase_ff;
      cmd.cor_idx  = cnt_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         gbtf_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         gbtf_pkg::S_CAL:       cmd.cal_add   = 1'b1;
         gbtf_pkg::S_DIV_LOAD:  cmd.div_load  = 1'b1;
         gbtf_pkg::S_DIV_RUN:   cmd.div_step  = 1'b1;
         gbtf_pkg::S_DIV_STORE: cmd.div_store = 1'b1;
         gbtf_pkg::S_COR_INIT:  cmd.cor_init  = 1'b1;
         gbtf_pkg::S_COR_RUN:   cmd.cor_step  = 1'b1;
         gbtf_pkg::S_MAG:       cmd.mag       = 1'b1;
         gbtf_pkg::S_TRK_MUL:   cmd.trk_mul   = 1'b1;
         gbtf_pkg::S_TRK_G:     cmd.trk_g     = 1'b1;
         gbtf_pkg::S_TRK_MIX:   cmd.trk_mix   = 1'b1;
         gbtf_pkg::S_TRK_SUM:   cmd.trk_sum   = 1'b1;
         gbtf_pkg::S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbtf_pkg::S_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/gbtf_dp.sv
// ----------------------------------------------------------------------------
// gbtf_dp: datapath of the tilt filter
// Bias sums, reciprocal divider, shared CORDIC, gyro/accel blend, registers.
// ----------------------------------------------------------------------------
module gbtf_dp #(
   parameter int CAL_SAMPLES = gbtf_pkg::CAL_SAMPLES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gbtf_pkg::cmd_type               cmd,
   output gbtf_pkg::stat_type              stat,
   input  logic signed [15:0]              accel_x,
   input  logic signed [15:0]              accel_y,
   input  logic signed [15:0]              accel_z,
   input  logic signed [15:0]              gyro_x,
   input  logic signed [15:0]              gyro_y,
   input  logic                            csr_we,
   input  logic [gbtf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbtf_pkg::CSR_DATA_W-1:0] csr_data,
   output logic signed [16:0]              roll_angle,
   output logic signed [16:0]              pitch_angle
);

   localparam int CW = $clog2(CAL_SAMPLES + 1);
   localparam int DW = gbtf_pkg::DIV_W;
   localparam int HW = DW / 2;
   // floor(n * RECIP >> RK) == floor(n / CAL_SAMPLES) for every n below 2^DW
   localparam int RL = $clog2(CAL_SAMPLES);
   localparam int RK = DW + RL;
   localparam int MW = DW + 2;
   localparam int PW = HW + MW;
   localparam int AW = DW + MW;
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << RK) + 64'(CAL_SAMPLES - 1)) / 64'(CAL_SAMPLES));

   // configuration
   logic [16:0] alpha_ff;
   logic [23:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= gbtf_pkg::ALPHA_RESET;
         gain_ff  <= gbtf_pkg::GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            gbtf_pkg::CSR_BLEND_ALPHA: alpha_ff <= csr_data[16:0];
            gbtf_pkg::CSR_RATE_GAIN:   gain_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // sample latch
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff;
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         ax_ff <= accel_x;
         ay_ff <= accel_y;
         az_ff <= accel_z;
         gx_ff <= gyro_x;
         gy_ff <= gyro_y;
      end
   end

   // calibration and bias
   logic [CW-1:0]      count_ff;
   logic signed [27:0] sum_x_ff, sum_y_ff;
   logic signed [23:0] bias_x_ff, bias_y_ff;
   logic [DW-1:0]      num_ff;
   logic [AW-1:0]      acc_ff;
   logic               neg_ff;

   logic signed [27:0] sum_sel;
   logic [27:0]        sum_mag;
   logic [PW-1:0]      part;
   logic [AW-1:0]      acc_next;
   logic [23:0]        quo;
   logic signed [23:0] bias_new;

   assign stat.cal_done = (count_ff == CW'(CAL_SAMPLES));
   assign stat.cal_last = (count_ff == CW'(CAL_SAMPLES - 1));

   // upper numerator half first, then shifted in with the lower half
   always_comb begin
      sum_sel  = cmd.axis ? sum_y_ff : sum_x_ff;
      sum_mag  = sum_sel[27] ? 28'(-sum_sel) : sum_sel;
      part     = num_ff[DW-1:HW] * RECIP;
      acc_next = (acc_ff << HW) + AW'(part);
      quo      = 24'(acc_ff >> RK);
      bias_new = neg_ff ? 24'(-quo) : quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         bias_x_ff <= '0;
         bias_y_ff <= '0;
      end else begin
         if (cmd.cal_add) begin
            count_ff <= count_ff + 1'b1;
            sum_x_ff <= sum_x_ff + 28'(gx_ff);
            sum_y_ff <= sum_y_ff + 28'(gy_ff);
         end
         if (cmd.div_store) begin
            if (cmd.axis) begin
               bias_y_ff <= bias_new;
            end else begin
               bias_x_ff <= bias_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         num_ff <= DW'({sum_mag, 8'd0}) + DW'(CAL_SAMPLES / 2);
         neg_ff <= sum_sel[27];
         acc_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[HW-1:0], {HW{1'b0}}};
         acc_ff <= acc_next;
      end
   end

   // CORDIC vectoring, shared by both passes
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [27:0] cz_ff;
   logic signed [27:0] acc_roll_ff;
   logic [31:0]        mag_ff;

   logic signed [33:0] x0, y0, xs, ys;
   logic signed [27:0] at;
   logic [61:0]        mag_prod;

   always_comb begin
      if (cmd.axis) begin
         y0 = -(34'(ax_ff) <<< 14);
         x0 = {2'b00, mag_ff};
      end else begin
         y0 = 34'(ay_ff) <<< 14;
         x0 = 34'(az_ff) <<< 14;
      end
      xs       = cx_ff >>> cmd.cor_idx;
      ys       = cy_ff >>> cmd.cor_idx;
      at       = 28'(gbtf_pkg::atan_deg(cmd.cor_idx));
      mag_prod = cx_ff[31:0] * gbtf_pkg::INV_GAIN_Q30;
   end

   always_ff @(posedge clock) begin
      if (cmd.cor_init) begin
         if (x0 < 0) begin
            cx_ff <= -x0;
            cy_ff <= -y0;
            cz_ff <= (y0 >= 0) ? gbtf_pkg::HALF_TURN : -gbtf_pkg::HALF_TURN;
         end else begin
            cx_ff <= x0;
            cy_ff <= y0;
            cz_ff <= '0;
         end
      end else if (cmd.cor_step) begin
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + at;
         end else if (cy_ff < 0) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - at;
         end
      end
      if (cmd.mag) begin
         mag_ff      <= mag_prod[61:30];
         acc_roll_ff <= cz_ff;
      end
   end

   // gyro integration and blend
   logic signed [27:0] roll_ff, pitch_ff;
   logic signed [49:0] prod_ff;
   logic signed [27:0] g_ff;
   logic signed [45:0] pa_ff, pb_ff;

   logic signed [15:0] gyro_sel;
   logic signed [23:0] bias_sel;
   logic signed [27:0] st_sel, acc_sel;
   logic signed [24:0] diff;
   logic signed [49:0] prod_rnd;
   logic signed [25:0] step;
   logic [16:0]        alpha_eff, beta;
   logic signed [47:0] mix;
   logic signed [27:0] st_new;

   always_comb begin
      gyro_sel  = cmd.axis ? gy_ff : gx_ff;
      bias_sel  = cmd.axis ? bias_y_ff : bias_x_ff;
      st_sel    = cmd.axis ? pitch_ff : roll_ff;
      acc_sel   = cmd.axis ? cz_ff : acc_roll_ff;
      diff      = (25'(gyro_sel) <<< 8) - 25'(bias_sel);
      prod_rnd  = prod_ff + 50'sd8388608;
      step      = prod_rnd[49:24];
      alpha_eff = (alpha_ff > gbtf_pkg::ALPHA_ONE) ? gbtf_pkg::ALPHA_ONE : alpha_ff;
      beta      = gbtf_pkg::ALPHA_ONE - alpha_eff;
      mix       = 48'(pa_ff) + 48'(pb_ff) + 48'sd32768;
      st_new    = gbtf_pkg::sat_ang(mix[47:16]);
   end

   always_ff @(posedge clock) begin
      if (cmd.trk_mul) begin
         prod_ff <= diff * $signed({1'b0, gain_ff});
      end
      if (cmd.trk_g) begin
         g_ff <= gbtf_pkg::sat_ang(32'(st_sel) + 32'(step));
      end
      if (cmd.trk_mix) begin
         pa_ff <= $signed({1'b0, alpha_eff}) * g_ff;
         pb_ff <= $signed({1'b0, beta}) * acc_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff  <= '0;
         pitch_ff <= '0;
      end else if (cmd.trk_sum) begin
         if (cmd.axis) begin
            pitch_ff <= st_new;
         end else begin
            roll_ff <= st_new;
         end
      end
   end

   // result register: floor to 1/64 degree, top clamp
   logic signed [17:0] ro, po;
   logic signed [16:0] roll_out_ff, pitch_out_ff;
   assign ro = roll_ff[27:10];
   assign po = pitch_ff[27:10];

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         roll_out_ff  <= (ro > 18'sd65535) ? 17'sd65535 : ro[16:0];
         pitch_out_ff <= (po > 18'sd65535) ? 17'sd65535 : po[16:0];
      end
   end

   assign roll_angle  = roll_out_ff;
   assign pitch_angle = pitch_out_ff;

endmodule

### design/gyro_bias_complementary_tilt_filter.sv
// ----------------------------------------------------------------------------
// gyro_bias_complementary_tilt_filter: roll/pitch complementary filter
// Gyro bias calibration, CORDIC accel tilt, gyro integration and blend.
// ----------------------------------------------------------------------------
// One raw IMU sample is taken per req transfer while req.ready is high. The
// first CAL_SAMPLES samples only build the gyro bias sums and give no result;
// the last of them starts the bias division (a reciprocal multiply done in
// two half-width passes per axis) that ends before the next sample is taken.
// Each later sample produces one rsp transfer: the CORDIC unit iterates once
// per cycle, first for roll, then for pitch on the scaled roll vector length,
// followed by four steps of gyro integration and blending per axis. A result
// sits in an output register; the next sample is accepted while it waits, and
// the block only stalls at the end of the following sample if the earlier
// result is still not taken. Registers (blend_alpha at index 0, rate_gain at
// index 1) are written through the csr channel, which is always ready; other
// indexes are ignored.
// ----------------------------------------------------------------------------
module gyro_bias_complementary_tilt_filter #(
   parameter int CAL_SAMPLES  = gbtf_pkg::CAL_SAMPLES_DEF,
   parameter int CORDIC_STEPS = gbtf_pkg::CORDIC_STEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gbtf_req_if.sink   req_chan,
   gbtf_rsp_if.source rsp_chan,
   gbtf_csr_if.sink   csr_chan
);

   gbtf_pkg::cmd_type  cmd;
   gbtf_pkg::stat_type stat;

   // register writes never stall
   assign csr_chan.ready = 1'b1;

   gbtf_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gbtf_dp #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .accel_x     (req_chan.accel_x),
      .accel_y     (req_chan.accel_y),
      .accel_z     (req_chan.accel_z),
      .gyro_x      (req_chan.gyro_x),
      .gyro_y      (req_chan.gyro_y),
      .csr_we      (csr_chan.valid),
      .csr_index   (csr_chan.reg_index),
      .csr_data    (csr_chan.data),
      .roll_angle  (rsp_chan.roll_angle),
      .pitch_angle (rsp_chan.pitch_angle)
   );

endmodule

### design/gbtf_checker.sv
// ----------------------------------------------------------------------------
// gbtf_checker: port-level checks of the tilt filter
// Handshake holding and sequencing seen at the channels.
// ----------------------------------------------------------------------------
module gbtf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [16:0] roll_angle,
   input logic [16:0] pitch_angle
);

   // a stalled result keeps valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(roll_angle) && $stable(pitch_angle))
      else $error("rsp payload changed while stalled");

   // one sample at a time: busy right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready right after a transfer");

   // a new result is only raised from the busy sequence
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("rsp raised while idle");

endmodule

bind gyro_bias_complementary_tilt_filter gbtf_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .roll_angle  (rsp_chan.roll_angle),
   .pitch_angle (rsp_chan.pitch_angle)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the gyro bias complementary tilt filter
// Runs the gyro bias calibration, then directed and random IMU samples
// under several blend/gain settings. A scoreboard predicts each angle
// transfer and checks it. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int CAL_N   = gbtf_pkg::CAL_SAMPLES_DEF;
   localparam int STEPS   = gbtf_pkg::CORDIC_STEPS_DEF;
   localparam longint LIM = 64'sd67108864;     // 1024 deg, Q16
   localparam longint HALF_TURN_Q16 = 64'sd11796480;
   localparam logic [gbtf_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd2;   // no register here
   localparam logic [gbtf_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam int SETTLE = 200;   // covers the divider and one sample

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] gx;
      logic signed [15:0] gy;
   } imu_sample_type;

   typedef struct packed {
      logic signed [16:0] roll;
      logic signed [16:0] pitch;
   } tilt_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of filter state, config and the pending angles
   // -------------------------------------------------------------------------
   class tilt_scoreboard_type;
      longint   alpha, gain;
      int       cal_taken;
      longint   sum_x, sum_y, bias_x, bias_y, roll_q16, pitch_q16;
      tilt_type pending_tilt[$];
      int       errors;
      longint   atan_q16[24];

      function new();
         atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                      57, 29, 14, 7, 4, 2, 1, 0};
         alpha = gbtf_pkg::ALPHA_RESET;
         gain = gbtf_pkg::GAIN_RESET;
         cal_taken = 0;
         sum_x = 0; sum_y = 0; bias_x = 0; bias_y = 0;
         roll_q16 = 0; pitch_q16 = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [gbtf_pkg::CSR_IDX_W-1:0] idx,
                              logic [gbtf_pkg::CSR_DATA_W-1:0] d);
         if (idx == gbtf_pkg::CSR_BLEND_ALPHA) alpha = d[16:0];
         else if (idx == gbtf_pkg::CSR_RATE_GAIN) gain = d;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // round(sum*256/N), ties away from zero
      function longint bias_of(longint s);
         longint n;
         n = s * 256;
         if (n >= 0) return (n + CAL_N / 2) / CAL_N;
         return -((-n + CAL_N / 2) / CAL_N);
      endfunction

      // vectoring CORDIC, angle in Q16 degrees; len gets the grown x
      function longint vec_angle(longint y, longint x, output longint len);
         longint z, xs, ys;
         z = 0;
         if (x < 0) begin
            z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x += ys; y -= xs; z += atan_q16[i];
            end else if (y < 0) begin
               x -= ys; y += xs; z -= atan_q16[i];
            end
         end
         len = x;
         return z;
      endfunction

      function longint blend(longint st, longint rate, longint bias, longint acc,
                             longint a);
         longint step, g, mix;
         step = (((rate * 256) - bias) * gain + (64'sd1 <<< 23)) >>> 24;
         g = clip(st + step, -LIM, LIM);
         mix = (a * g + (65536 - a) * acc + 32768) >>> 16;
         return clip(mix, -LIM, LIM);
      endfunction

      function void note_sample(imu_sample_type s);
         longint len, dummy, mag, acc_roll, acc_pitch, a;
         tilt_type t;
         if (cal_taken < CAL_N) begin
            sum_x += s.gx;
            sum_y += s.gy;
            cal_taken++;
            if (cal_taken == CAL_N) begin
               bias_x = bias_of(sum_x);
               bias_y = bias_of(sum_y);
            end
            return;
         end
         acc_roll = vec_angle(longint'(s.ay) * 16384, longint'(s.az) * 16384, len);
         mag = (len * 64'sd652032875) >>> 30;
         acc_pitch = vec_angle(-longint'(s.ax) * 16384, mag, dummy);
         a = alpha > 65536 ? 65536 : alpha;
         roll_q16 = blend(roll_q16, s.gx, bias_x, acc_roll, a);
         pitch_q16 = blend(pitch_q16, s.gy, bias_y, acc_pitch, a);
         t.roll = 17'(clip(roll_q16 >>> 10, -65536, 65535));
         t.pitch = 17'(clip(pitch_q16 >>> 10, -65536, 65535));
         pending_tilt.push_back(t);
      endfunction

      function void check_tilt(logic signed [16:0] roll, logic signed [16:0] pitch);
         tilt_type t;
         if (pending_tilt.size() == 0) begin
            $error("unexpected angle transfer roll=%0d pitch=%0d", roll, pitch);
            errors++;
            return;
         end
         t = pending_tilt.pop_front();
         if (roll !== t.roll) begin
            $error("roll_angle: expected %0d, got %0d", t.roll, roll);
            errors++;
         end
         if (pitch !== t.pitch) begin
            $error("pitch_angle: expected %0d, got %0d", t.pitch, pitch);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   gbtf_req_if req ();
   gbtf_rsp_if rsp ();
   gbtf_csr_if csr ();
   tilt_scoreboard_type sb = new();
   bit quiet_in, quiet_out;   // stretches with no idling

   always #10 clock = ~clock;

   gyro_bias_complementary_tilt_filter DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req),
      .rsp_chan(rsp),
      .csr_chan(csr)
   );

   // mostly short gaps, a few long ones
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [15:0] edge_val();
      case ($urandom_range(0, 4))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return 16'sd1;
      endcase
   endfunction

   function automatic imu_sample_type rand_sample();
      imu_sample_type s;
      int r;
      r = $urandom_range(0, 99);
      s = imu_sample_type'(80'({$urandom, $urandom, $urandom}));
      if (r < 60) begin
         // plausible attitude: gravity-sized accel, gyro near the bias
         s.ax = 16'($signed($urandom_range(0, 40000)) - 20000);
         s.ay = 16'($signed($urandom_range(0, 40000)) - 20000);
         s.az = 16'($signed($urandom_range(0, 40000)) - 20000);
         s.gx = 16'($signed($urandom_range(0, 1000)) - 500);
         s.gy = 16'($signed($urandom_range(0, 1000)) - 500);
      end else if (r < 70) begin
         s.ax = edge_val(); s.ay = edge_val(); s.az = edge_val();
         s.gx = edge_val(); s.gy = edge_val();
      end
      return s;
   endfunction

   // one sample transfer; valid stays high into the next call when no gap
   task automatic send_sample(imu_sample_type s);
      @(negedge clock);
      req.valid = 1'b1;
      {req.accel_x, req.accel_y, req.accel_z, req.gyro_x, req.gyro_y} = s;
      do @(posedge clock); while (!req.ready);
      sb.note_sample(s);
   endtask

   task automatic idle_in(int n);
      if (n > 0) begin
         @(negedge clock);
         req.valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_paced(imu_sample_type s);
      send_sample(s);
      idle_in(pick_gap(quiet_in));
   endtask

   task automatic write_reg(logic [gbtf_pkg::CSR_IDX_W-1:0] idx,
                            logic [gbtf_pkg::CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr.valid = 1'b1;
      csr.reg_index = idx;
      csr.data = d;
      do @(posedge clock); while (!csr.ready);
      sb.write_reg(idx, d);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   // all angles back, then room for a sample or the divider still running
   task automatic wait_idle();
      idle_in(1);
      while (sb.pending_tilt.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // result side: bursts of ready and stalls, decided at the falling edge
   initial begin
      int hold;
      hold = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            if (rsp.ready || quiet_out) begin
               hold = quiet_out ? 8 : pick_gap(1'b0);
               rsp.ready = (hold == 0) || quiet_out;
               if (hold == 0) hold = $urandom_range(1, 12);
            end else begin
               rsp.ready = 1'b1;
               hold = $urandom_range(1, 12);
            end
         end else begin
            hold--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check_tilt(rsp.roll_angle, rsp.pitch_angle);
   end

   initial begin
      imu_sample_type s;
      logic [gbtf_pkg::CSR_DATA_W-1:0] alpha_set [6];
      logic [gbtf_pkg::CSR_DATA_W-1:0] gain_set [6];
      req.valid = 1'b0;
      {req.accel_x, req.accel_y, req.accel_z, req.gyro_x, req.gyro_y} = '0;
      csr.valid = 1'b0;
      csr.reg_index = '0;
      csr.data = '0;
      quiet_in = 1'b0;
      quiet_out = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_reg(gbtf_pkg::CSR_BLEND_ALPHA, 24'(gbtf_pkg::ALPHA_RESET));
      write_reg(gbtf_pkg::CSR_RATE_GAIN, gbtf_pkg::GAIN_RESET);

      // calibration: bias sums only, no angle transfers
      for (int i = 0; i < CAL_N; i++) begin
         s = rand_sample();
         s.gx = 16'($signed($urandom_range(0, 600)) - 300);
         s.gy = 16'($signed($urandom_range(0, 600)) - 200);
         if (i == 5) begin s.gx = -16'sd32768; s.gy = 16'sd32767; end
         if (i == 6) begin s.gx = 16'sd32767; s.gy = -16'sd32768; end
         send_paced(s);
      end
      wait_idle();   // divider must finish before config changes

      // directed: zero vector, half-turn cases, field extremes
      s = '0;
      send_paced(s);                                   // atan2(0,0)
      s.az = -16'sd16384; send_paced(s);               // x<0, y=0: +180
      s.ay = 16'sd100;    send_paced(s);               // x<0, y>0
      s.ay = -16'sd100;   send_paced(s);               // x<0, y<0: -180
      s = '{ax: 16'sd32767, ay: 16'sd32767, az: 16'sd32767,
             gx: 16'sd32767, gy: 16'sd32767};
      send_paced(s);
      s = '{ax: -16'sd32768, ay: -16'sd32768, az: -16'sd32768,
             gx: -16'sd32768, gy: -16'sd32768};
      send_paced(s);
      s = '{ax: -16'sd32768, ay: 16'sd0, az: 16'sd0, gx: 16'sd0, gy: 16'sd0};
      send_paced(s);
      s = '{ax: 16'sd0, ay: 16'sd32767, az: -16'sd32768,
             gx: 16'sd32767, gy: -16'sd32768};
      send_paced(s);
      // drive the states with full-scale gyro
      for (int i = 0; i < 8; i++) begin
         s = '{ax: 16'sd0, ay: 16'sd0, az: 16'sd16384,
               gx: 16'sd32767, gy: -16'sd32768};
         send_paced(s);
      end
      wait_idle();
      write_reg(gbtf_pkg::CSR_RATE_GAIN, 24'hFFFFFF);
      write_reg(gbtf_pkg::CSR_BLEND_ALPHA, 24'(gbtf_pkg::ALPHA_ONE));
      for (int i = 0; i < 6; i++) begin
         s = '{ax: 16'sd1000, ay: 16'sd0, az: 16'sd16384,
               gx: (i < 3) ? 16'sd32767 : -16'sd32768, gy: 16'sd32767};
         send_paced(s);
      end
      wait_idle();
      write_reg(CSR_SPARE, 24'h000000);      // ignored indexes
      write_reg(CSR_SPARE_HI, 24'hFFFFFF);

      // random phases under various settings, extremes among them
      alpha_set = '{24'($urandom_range(0, 65536)), 24'd0, 24'(gbtf_pkg::ALPHA_ONE),
                    24'h01FFFF, 24'(gbtf_pkg::ALPHA_RESET),
                    24'($urandom_range(60000, 65536))};
      gain_set  = '{24'($urandom), 24'hFFFFFF, 24'd0, 24'($urandom),
                    gbtf_pkg::GAIN_RESET, 24'($urandom_range(0, 1000000))};
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         write_reg(gbtf_pkg::CSR_BLEND_ALPHA, alpha_set[p]);
         write_reg(gbtf_pkg::CSR_RATE_GAIN, gain_set[p]);
         for (int i = 0; i < 170; i++) begin
            if (i % 40 == 0) begin
               quiet_in = ($urandom_range(0, 3) == 0);
               quiet_out = ($urandom_range(0, 3) == 0);
            end
            send_paced(rand_sample());
         end
      end

      quiet_out = 1'b0;
      wait_idle();
      if (sb.errors == 0 && sb.pending_tilt.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #60000000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
